>>> rtl/grid_detection_box_decode_core_defines.svh
// Assertion macros for the grid detection box decode core.
// Included by the top level; no other dependencies.
`ifndef GRID_DETECTION_BOX_DECODE_CORE_DEFINES_SVH
`define GRID_DETECTION_BOX_DECODE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GDBD_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GDBD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/gdbd_pkg.sv
// Shared types and constants for the grid detection box decode core.
// No dependencies.
`timescale 1ns / 1ps

package gdbd_pkg;

   localparam int GRID_SIDE_DEF = 7;
   localparam int NUM_CLASSES   = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd2;

   localparam logic [15:0] THRESHOLD_RST  = 16'd3277;
   localparam logic [12:0] IMAGE_SIZE_RST = 13'd448;

   typedef struct packed {
      logic [2:0]         cell_row;
      logic [2:0]         cell_col;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_w;
      logic signed [15:0] raw_h;
      logic signed [15:0] box_confidence;
      logic signed [15:0] class_prob_zero;
      logic signed [15:0] class_prob_one;
   } req_word_type;

   typedef struct packed {
      logic [15:0] box_x;
      logic [15:0] box_y;
      logic [15:0] box_w;
      logic [15:0] box_h;
      logic [15:0] best_score;
      logic        class_found;
      logic        win_class;
   } rsp_word_type;

endpackage

>>> rtl/grid_detection_box_decode_core.sv
// Grid detection box decode core: six-stage pipeline, one box word per cycle.
// Depends on gdbd_pkg and grid_detection_box_decode_core_defines.svh.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+---------------------------
//   request | start, busy, req_data                  | taken when start & !busy
//   result  | rsp_valid, rsp_data                    | one-cycle strobe, no stall
//   config  | csr_valid, csr_ready, csr_index/data   | taken when valid & ready
//
// One word per cycle while busy is low; each request passes the stage 1 to 5 registers,
// then rsp_ff. Latency is set by the squaring, the 33x13 pixel-scale multiply
// and the reciprocal multiply that divides by the grid side, each in its own stage.
// csr_ready drops while busy or start is high or any word is in flight.
// Reset is synchronous; busy is set at a reset edge and cleared at the first edge with
// reset low, and the pipeline is emptied. The receiver cannot stall.
`timescale 1ns / 1ps
`include "grid_detection_box_decode_core_defines.svh"

module grid_detection_box_decode_core #(
   parameter int GRID_SIDE = gdbd_pkg::GRID_SIDE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  gdbd_pkg::req_word_type              req_data,
   output logic                                rsp_valid,
   output gdbd_pkg::rsp_word_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gdbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gdbd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import gdbd_pkg::*;

   localparam int GL     = $clog2(GRID_SIDE);
   localparam int TW     = 17 + GL;
   localparam int SHIFT  = TW + GL;
   localparam int MW     = TW + 1;
   localparam int PW     = TW + MW;
   localparam int NW     = 33;
   localparam int PXW    = NW + 13;
   localparam int TRW    = PXW - 25;
   localparam int PWW    = 31 + 13;
   localparam int NXW    = 36;
   localparam int STAGES = 6;
   localparam logic [MW-1:0]  RECIP = MW'((2**SHIFT + GRID_SIDE - 1) / GRID_SIDE);
   localparam logic [TRW-1:0] TSAT  = TRW'(65536 * GRID_SIDE);

   typedef struct packed {
      logic [15:0] best;
      logic        found;
      logic        idx;
   } score_type;

   function automatic logic [15:0] clamp_coord(input logic [15:0] q,
                                               input logic [12:0] size);
      logic [16:0] lim;
      lim = {size, 4'd0} - 17'd16;
      if (size == 13'd0) begin
         return 16'd0;
      end else if ({1'b0, q} > lim) begin
         return lim[15:0];
      end
      return q;
   endfunction

   logic                busy_ff;
   logic                acc;
   logic [STAGES-1:0]   vld_ff, vld_in;
   logic [15:0]         thr_ff;
   logic [12:0]         width_ff, height_ff;

   // stage 1
   logic signed [31:0]  wprod_c, hprod_c;
   logic [30:0]         wsq1_ff, hsq1_ff;
   logic signed [31:0]  p0_1_ff, p1_1_ff, p0_1_in, p1_1_in;
   logic signed [18:0]  xs1_ff, ys1_ff, xs1_in, ys1_in;

   // stage 2
   logic signed [NXW-1:0] nx_c, ny_c;
   logic [NW-1:0]       nxp2_ff, nyp2_ff, nxp2_in, nyp2_in;
   logic [30:0]         wsq2_ff, hsq2_ff;
   logic [16:0]         s0_c, s1_c, sbest_c;
   logic                ok0_c, ok1_c;
   score_type           sc2_ff, sc2_in, sc3_ff, sc4_ff, sc5_ff;

   // stage 3
   logic [PXW-1:0]      px3_ff, py3_ff;
   logic [PWW-1:0]      pw3_ff, ph3_ff;

   // stage 4
   logic [TRW-1:0]      tx_c, ty_c;
   logic [19:0]         qw_c, qh_c;
   logic [TW-1:0]       tx4_ff, ty4_ff, tx4_in, ty4_in;
   logic [15:0]         qw4_ff, qh4_ff, qw4_in, qh4_in;

   // stage 5
   logic [PW-1:0]       mx5_ff, my5_ff;
   logic [15:0]         qw5_ff, qh5_ff;

   // stage 6
   logic [16:0]         qx_c, qy_c;
   rsp_word_type        rsp_ff, rsp_in;

   assign acc       = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff && !start && (vld_ff == '0);
   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_data  = rsp_ff;
   assign vld_in    = {vld_ff[STAGES-2:0], acc};

   always_comb begin
      wprod_c = req_data.raw_w * req_data.raw_w;
      hprod_c = req_data.raw_h * req_data.raw_h;
      p0_1_in = req_data.box_confidence * req_data.class_prob_zero;
      p1_1_in = req_data.box_confidence * req_data.class_prob_one;
      xs1_in  = $signed({{3{req_data.raw_x[15]}}, req_data.raw_x})
                + $signed({2'b00, req_data.cell_col, 14'd0});
      ys1_in  = $signed({{3{req_data.raw_y[15]}}, req_data.raw_y})
                + $signed({2'b00, req_data.cell_row, 14'd0});
   end

   always_comb begin
      nx_c = $signed({{2{xs1_ff[18]}}, xs1_ff, 15'd0})
             - $signed(NXW'(wsq1_ff) * NXW'(GRID_SIDE));
      ny_c = $signed({{2{ys1_ff[18]}}, ys1_ff, 15'd0})
             - $signed(NXW'(hsq1_ff) * NXW'(GRID_SIDE));
      nxp2_in = (!nx_c[NXW-1] && nx_c != '0) ? nx_c[NW-1:0] : '0;
      nyp2_in = (!ny_c[NXW-1] && ny_c != '0) ? ny_c[NW-1:0] : '0;

      s0_c  = p0_1_ff[30:14];
      s1_c  = p1_1_ff[30:14];
      ok0_c = !p0_1_ff[31] && (p0_1_ff != '0) && (s0_c > {1'b0, thr_ff});
      ok1_c = (NUM_CLASSES > 1) && !p1_1_ff[31] && (p1_1_ff != '0)
              && (s1_c > {1'b0, thr_ff}) && (!ok0_c || (s1_c > s0_c));
      if (ok1_c) begin
         sbest_c = s1_c;
      end else if (ok0_c) begin
         sbest_c = s0_c;
      end else begin
         sbest_c = '0;
      end
      sc2_in.best  = sbest_c[16] ? 16'hFFFF : sbest_c[15:0];
      sc2_in.found = ok0_c || ok1_c;
      sc2_in.idx   = ok1_c;
   end

   always_comb begin
      tx_c   = px3_ff[PXW-1:25];
      ty_c   = py3_ff[PXW-1:25];
      tx4_in = (tx_c > TSAT) ? TSAT[TW-1:0] : tx_c[TW-1:0];
      ty4_in = (ty_c > TSAT) ? TSAT[TW-1:0] : ty_c[TW-1:0];
      qw_c   = pw3_ff[PWW-1:24];
      qh_c   = ph3_ff[PWW-1:24];
      qw4_in = (|qw_c[19:16]) ? 16'hFFFF : qw_c[15:0];
      qh4_in = (|qh_c[19:16]) ? 16'hFFFF : qh_c[15:0];
   end

   always_comb begin
      qx_c               = mx5_ff[SHIFT +: 17];
      qy_c               = my5_ff[SHIFT +: 17];
      rsp_in.box_x       = clamp_coord(qx_c[16] ? 16'hFFFF : qx_c[15:0], width_ff);
      rsp_in.box_y       = clamp_coord(qy_c[16] ? 16'hFFFF : qy_c[15:0], height_ff);
      rsp_in.box_w       = clamp_coord(qw5_ff, width_ff);
      rsp_in.box_h       = clamp_coord(qh5_ff, height_ff);
      rsp_in.best_score  = sc5_ff.best;
      rsp_in.class_found = sc5_ff.found;
      rsp_in.win_class   = sc5_ff.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         vld_ff    <= '0;
         thr_ff    <= THRESHOLD_RST;
         width_ff  <= IMAGE_SIZE_RST;
         height_ff <= IMAGE_SIZE_RST;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= vld_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCORE_THRESHOLD: thr_ff    <= csr_data;
               CSR_IMAGE_WIDTH:     width_ff  <= csr_data[12:0];
               CSR_IMAGE_HEIGHT:    height_ff <= csr_data[12:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      wsq1_ff <= wprod_c[30:0];
      hsq1_ff <= hprod_c[30:0];
      p0_1_ff <= p0_1_in;
      p1_1_ff <= p1_1_in;
      xs1_ff  <= xs1_in;
      ys1_ff  <= ys1_in;

      nxp2_ff <= nxp2_in;
      nyp2_ff <= nyp2_in;
      wsq2_ff <= wsq1_ff;
      hsq2_ff <= hsq1_ff;
      sc2_ff  <= sc2_in;

      px3_ff  <= PXW'(nxp2_ff) * PXW'(width_ff);
      py3_ff  <= PXW'(nyp2_ff) * PXW'(height_ff);
      pw3_ff  <= PWW'(wsq2_ff) * PWW'(width_ff);
      ph3_ff  <= PWW'(hsq2_ff) * PWW'(height_ff);
      sc3_ff  <= sc2_ff;

      tx4_ff  <= tx4_in;
      ty4_ff  <= ty4_in;
      qw4_ff  <= qw4_in;
      qh4_ff  <= qh4_in;
      sc4_ff  <= sc3_ff;

      mx5_ff  <= PW'(tx4_ff) * PW'(RECIP);
      my5_ff  <= PW'(ty4_ff) * PW'(RECIP);
      qw5_ff  <= qw4_ff;
      qh5_ff  <= qh4_ff;
      sc5_ff  <= sc4_ff;

      rsp_ff  <= rsp_in;
   end

   `GDBD_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, $past(acc, STAGES), "result without request")
   `GDBD_ASSERT_IMPLY(a_none_is_zero, clock, reset, rsp_valid && !rsp_data.class_found, (rsp_data.best_score == 16'd0) && !rsp_data.win_class, "no class but nonzero score")
   `GDBD_ASSERT_IMPLY(a_found_above_thr, clock, reset, rsp_valid && rsp_data.class_found, rsp_data.best_score >= thr_ff, "winning score below threshold")
   `GDBD_ASSERT_NEXT(a_thr_write, clock, reset, csr_valid && csr_ready && (csr_index == CSR_SCORE_THRESHOLD), thr_ff == $past(csr_data), "threshold write lost")

endmodule

>>> tb/box_decode_monitor.sv
// Box decode monitor: watches the request, result and register channels of the core.
// It predicts each decoded box and counts mismatches. Depends on gdbd_pkg.
`timescale 1ns / 1ps

module box_decode_monitor #(
   parameter int GRID_SIDE = gdbd_pkg::GRID_SIDE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  gdbd_pkg::req_word_type           req_data,
   input  logic                             rsp_valid,
   input  gdbd_pkg::rsp_word_type           rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [gdbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gdbd_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatches,
   output int                               outstanding
);
   import gdbd_pkg::*;

   logic [15:0]  threshold_q;
   logic [12:0]  width_q;
   logic [12:0]  height_q;
   rsp_word_type expected_boxes[$];
   int           boxes_seen;

   function automatic logic [15:0] to_pixels(longint num, longint den, longint size);
      longint q;
      longint lim;
      if (size == 0 || num <= 0)
         return '0;
      q   = (num * size * 16) / den;
      lim = (size - 1) * 16;
      if (q > lim)
         q = lim;
      if (q > 65535)
         q = 65535;
      return q[15:0];
   endfunction

   function automatic rsp_word_type decode_box(req_word_type b);
      rsp_word_type r;
      longint       wq;
      longint       hq;
      longint       nx;
      longint       ny;
      longint       den_c;
      longint       conf;
      longint       prob[2];
      longint       p;
      longint       s;
      longint       best;
      r     = '0;
      wq    = longint'($signed(b.raw_w)) * longint'($signed(b.raw_w));
      hq    = longint'($signed(b.raw_h)) * longint'($signed(b.raw_h));
      den_c = longint'(GRID_SIDE) << 29;
      nx    = (longint'($signed(b.raw_x)) + longint'(b.cell_col) * 16384) * 32768
              - wq * GRID_SIDE;
      ny    = (longint'($signed(b.raw_y)) + longint'(b.cell_row) * 16384) * 32768
              - hq * GRID_SIDE;
      r.box_x = to_pixels(nx, den_c, longint'(width_q));
      r.box_y = to_pixels(ny, den_c, longint'(height_q));
      r.box_w = to_pixels(wq, longint'(1) << 28, longint'(width_q));
      r.box_h = to_pixels(hq, longint'(1) << 28, longint'(height_q));
      conf    = longint'($signed(b.box_confidence));
      prob[0] = longint'($signed(b.class_prob_zero));
      prob[1] = longint'($signed(b.class_prob_one));
      best    = 0;
      for (int j = 0; j < NUM_CLASSES && j < 2; j++) begin
         p = conf * prob[j];
         if (p > 0) begin
            s = p >>> 14;
            if (s > longint'(threshold_q) && s > best) begin
               best          = s;
               r.class_found = 1'b1;
               r.win_class   = j[0];
            end
         end
      end
      r.best_score = (best > 65535) ? 16'hFFFF : best[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] box %0d: %s", $time, boxes_seen, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         expected_boxes.delete();
         threshold_q <= THRESHOLD_RST;
         width_q     <= IMAGE_SIZE_RST;
         height_q    <= IMAGE_SIZE_RST;
      end else begin
         if (rsp_valid) begin
            if (expected_boxes.size() == 0) begin
               report_mismatch("result word with no request outstanding");
            end else begin
               want = expected_boxes.pop_front();
               check_field("box_x", rsp_data.box_x, want.box_x);
               check_field("box_y", rsp_data.box_y, want.box_y);
               check_field("box_w", rsp_data.box_w, want.box_w);
               check_field("box_h", rsp_data.box_h, want.box_h);
               check_field("best_score", rsp_data.best_score, want.best_score);
               check_field("class_found", 16'(rsp_data.class_found), 16'(want.class_found));
               check_field("win_class", 16'(rsp_data.win_class), 16'(want.win_class));
            end
            boxes_seen++;
         end
         if (start && !busy)
            expected_boxes.insert(expected_boxes.size(), decode_box(req_data));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCORE_THRESHOLD: threshold_q <= csr_data;
               CSR_IMAGE_WIDTH:     width_q     <= csr_data[12:0];
               CSR_IMAGE_HEIGHT:    height_q    <= csr_data[12:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_boxes.size();
   end

endmodule

>>> tb/tb.sv
// Top of the box decode testbench: clock, reset, box and register stimulus, verdict.
// Depends on gdbd_pkg, grid_detection_box_decode_core and box_decode_monitor.
`timescale 1ns / 1ps

module tb;
   import gdbd_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 200000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_word_type           req_data;
   logic                   rsp_valid;
   rsp_word_type           rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     mismatches;
   int                     outstanding;
   int                     cycle_count;
   int                     burst_left;

   grid_detection_box_decode_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   box_decode_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** grid_detection_box_decode_core: FAILED **");
         $finish;
      end
   end

   function automatic req_word_type make_box(int row, int col, int x, int y, int w, int h,
                                             int conf, int p0, int p1);
      req_word_type b;
      b.cell_row        = 3'(row);
      b.cell_col        = 3'(col);
      b.raw_x           = 16'(x);
      b.raw_y           = 16'(y);
      b.raw_w           = 16'(w);
      b.raw_h           = 16'(h);
      b.box_confidence  = 16'(conf);
      b.class_prob_zero = 16'(p0);
      b.class_prob_one  = 16'(p1);
      return b;
   endfunction

   function automatic req_word_type random_box();
      req_word_type b;
      logic [127:0] bits;
      if ($urandom_range(0, 9) < 7) begin
         b.cell_row        = 3'($urandom_range(0, 6));
         b.cell_col        = 3'($urandom_range(0, 6));
         b.raw_x           = 16'($urandom_range(0, 16383));
         b.raw_y           = 16'($urandom_range(0, 16383));
         b.raw_w           = 16'($urandom_range(0, 16384));
         b.raw_h           = 16'($urandom_range(0, 16384));
         b.box_confidence  = 16'($urandom_range(0, 16384));
         b.class_prob_zero = 16'($urandom_range(0, 16384));
         if ($urandom_range(0, 7) == 0)
            b.class_prob_one = b.class_prob_zero;
         else
            b.class_prob_one = 16'($urandom_range(0, 16384));
      end else begin
         bits = {$urandom, $urandom, $urandom, $urandom};
         b    = bits[$bits(req_word_type)-1:0];
      end
      return b;
   endfunction

   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   // hold the word until the core takes it
   task automatic send_box(req_word_type w);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] threshold, logic [15:0] width, logic [15:0] height);
      csr_write(CSR_SCORE_THRESHOLD, threshold);
      csr_write(CSR_IMAGE_WIDTH, width);
      csr_write(CSR_IMAGE_HEIGHT, height);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++)
         send_box(random_box());
      drain();
   endtask

   initial begin
      reset      <= 1'b1;
      start      <= 1'b0;
      req_data   <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      burst_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_box(make_box(7, 7, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF,
                        'h7FFF, 'h7FFF, 'h7FFF));
      send_box(make_box(7, 7, 'h8000, 'h8000, 'h8000, 'h8000,
                        'h8000, 'h8000, 'h8000));
      send_box(make_box(0, 0, 'h8000, 'h8000, 0, 0, 16384, -16384, 16384));
      send_box(make_box(3, 3, 8192, 8192, 8192, 8192, 16384, 16384, 8192));
      send_box(make_box(6, 6, 16383, 16383, 16384, 16384, 16384, 3277, 3277));
      send_box(make_box(6, 6, 16383, 16383, 16384, 16384, 16384, 3278, 3277));
      send_box(make_box(2, 5, 4096, 12288, 4000, 6000, 16384, 6000, 9000));
      send_box(make_box(5, 2, 12288, 4096, 6000, 4000, 16384, 9000, 9000));
      send_box(make_box(1, 4, 0, 0, 0, 0, -16384, -8192, -12000));
      send_box(make_box(4, 1, 100, 200, 300, 400, -16384, 8192, 8192));
      send_box(make_box(0, 6, 'h5555, 'hAAAA, 'h5555, 'hAAAA,
                        'h5555, 'hAAAA, 'h5555));
      send_box(make_box(6, 0, 'hAAAA, 'h5555, 'hAAAA, 'h5555,
                        'hAAAA, 'h5555, 'hAAAA));
      send_box(make_box(7, 0, 0, 0, 16384, 16384, 'h7FFF, 'h7FFF, 'h8000));
      send_box(make_box(0, 7, 16384, 16384, 1, 1, 1, 1, 1));
      send_box(make_box(3, 3, -1, -1, -1, -1, -1, -1, -1));
      drain();

      set_config(16'd0, 16'd1, 16'd1);
      run_random(70);
      set_config(16'hFFFF, 16'd4096, 16'd4096);
      run_random(50);
      set_config(16'($urandom_range(0, 65535)), 16'hFFFF, 16'h2000);
      run_random(60);
      csr_write(CSR_SPARE, 16'($urandom));
      set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 4096)),
                 16'($urandom_range(1, 4096)));
      run_random(80);
      set_config(16'($urandom_range(0, 8192)), 16'($urandom_range(1, 640)),
                 16'($urandom_range(1, 480)));
      run_random(80);
      set_config(THRESHOLD_RST, 16'(IMAGE_SIZE_RST), 16'(IMAGE_SIZE_RST));
      run_random(60);

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("** grid_detection_box_decode_core: PASSED **");
      else
         $display("** grid_detection_box_decode_core: FAILED **");
      $finish;
   end

endmodule

>>> grid_detection_box_decode_core.f
+incdir+rtl
rtl/gdbd_pkg.sv
rtl/grid_detection_box_decode_core.sv
tb/box_decode_monitor.sv
tb/tb.sv
